@@ sv/ira_pkg.sv @@
// Shared constants, codes and character helpers for the integer to ASCII formatter.
package ira_pkg;

    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 20;
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_SIGNED   = 2'd0;
    localparam logic [1:0] CMD_UNSIGNED = 2'd1;
    localparam logic [1:0] CMD_POINTER  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_MINUS = 2'd1;
    localparam logic [1:0] PRE_HEX   = 2'd2;
    localparam logic [1:0] PRE_NIL   = 2'd3;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWER  = 8'h61;
    localparam logic [7:0] CH_UPPER  = 8'h41;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Number of prefix characters for each prefix kind.
    function automatic logic [2:0] prefix_len(input logic [1:0] kind);
        logic [2:0] n;
        case (kind)
            PRE_MINUS: n = 3'd1;
            PRE_HEX:   n = 3'd2;
            PRE_NIL:   n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] c;
        c = CH_ZERO;
        case (kind)
            PRE_MINUS: c = CH_MINUS;
            PRE_HEX:   c = (idx == 3'd0) ? CH_ZERO : CH_X;
            PRE_NIL:
            begin
                case (idx)
                    3'd0:    c = CH_LPAREN;
                    3'd1:    c = CH_N;
                    3'd2:    c = CH_I;
                    3'd3:    c = CH_L;
                    default: c = CH_RPAREN;
                endcase
            end
            default:   c = CH_ZERO;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = (upper ? CH_UPPER : CH_LOWER) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ sv/ira_divider.sv @@
// Iterative divider of a 64-bit value by a small radix, several quotient bits per cycle.
module ira_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ira_pkg::VALUE_W-1:0]        dividend,
    input  logic [ira_pkg::RADIX_W-1:0]        divisor,
    output logic                               busy,
    output logic                               done,
    output logic [ira_pkg::VALUE_W-1:0]        quotient,
    output logic [ira_pkg::DIGIT_W-1:0]        remainder
);

    logic [ira_pkg::VALUE_W-1:0]   acc_reg;
    logic [ira_pkg::VALUE_W-1:0]   acc_next;
    logic [ira_pkg::DIGIT_W-1:0]   rem_reg;
    logic [ira_pkg::DIGIT_W-1:0]   rem_next;
    logic [ira_pkg::RADIX_W-1:0]   div_reg;
    logic [ira_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    // Long division over the top DIV_BITS bits of the shift register.
    always_comb
    begin
        logic [ira_pkg::RADIX_W-1:0]  r;
        logic [ira_pkg::DIV_BITS-1:0] qb;
        r  = {1'b0, rem_reg};
        qb = '0;
        for (int j = 0; j < ira_pkg::DIV_BITS; j++)
        begin
            r = {r[ira_pkg::DIGIT_W-1:0], acc_reg[ira_pkg::VALUE_W-1-j]};
            if (r >= div_reg)
            begin
                r = r - div_reg;
                qb[ira_pkg::DIV_BITS-1-j] = 1'b1;
            end
        end
        rem_next = r[ira_pkg::DIGIT_W-1:0];
        acc_next = {acc_reg[ira_pkg::VALUE_W-ira_pkg::DIV_BITS-1:0], qb};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                done_reg <= (cnt_reg == ira_pkg::DIV_CNT_W'(ira_pkg::DIV_STEPS - 1));
                if (cnt_reg == ira_pkg::DIV_CNT_W'(ira_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/integer_radix_to_ascii.sv @@
// Integer to ASCII formatter: top level with sequencer, digit buffer and output register.
// Each digit comes from the shared divider (8 quotient bits per cycle),
// then one character per cycle out while not back-pressured; "(nil)" needs no division.
// Items are handled one at a time.
// The input is ready again once the final character sits in the output register.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
module integer_radix_to_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd[1:0], value[65:2], radix[70:66], upper_case[71]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // ch[7:0]
    output logic        m_axis_tlast   // last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          pre_kind_reg;
    logic [2:0]                          pre_idx_reg;
    logic [ira_pkg::DIG_CNT_W-1:0]       ndig_reg;
    logic [ira_pkg::RADIX_W-1:0]         radix_reg;
    logic                                upper_reg;
    logic [ira_pkg::DIGIT_W-1:0]         dig_reg [ira_pkg::MAX_DIGITS];
    logic                                out_valid_reg;
    logic [7:0]                          out_ch_reg;
    logic                                out_last_reg;

    logic [1:0]                          in_cmd;
    logic [ira_pkg::VALUE_W-1:0]         in_value;
    logic [ira_pkg::RADIX_W-1:0]         in_radix;
    logic                                in_upper;
    logic                                in_xfer;
    logic                                is_ptr;
    logic                                is_neg;
    logic [1:0]                          kind_sel;
    logic [ira_pkg::RADIX_W-1:0]         radix_sel;
    logic [ira_pkg::VALUE_W-1:0]         mag_sel;

    logic                                div_start;
    logic [ira_pkg::VALUE_W-1:0]         div_dividend;
    logic [ira_pkg::RADIX_W-1:0]         div_divisor;
    logic                                div_busy;
    logic                                div_done;
    logic [ira_pkg::VALUE_W-1:0]         div_quot;
    logic [ira_pkg::DIGIT_W-1:0]         div_rem;

    logic                                out_free;
    logic                                emit;
    logic                                in_prefix;
    logic [2:0]                          pre_len;
    logic [ira_pkg::DIG_IDX_W-1:0]       rd_idx;
    logic [7:0]                          emit_ch;
    logic                                emit_last;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_value = s_axis_tdata[65:2];
    assign in_radix = s_axis_tdata[70:66];
    assign in_upper = s_axis_tdata[71];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign is_ptr = (in_cmd == ira_pkg::CMD_POINTER);
    assign is_neg = (in_cmd == ira_pkg::CMD_SIGNED) && in_value[ira_pkg::VALUE_W-1];

    always_comb
    begin
        if (is_ptr)
        begin
            kind_sel = (in_value == '0) ? ira_pkg::PRE_NIL : ira_pkg::PRE_HEX;
        end
        else if (is_neg)
        begin
            kind_sel = ira_pkg::PRE_MINUS;
        end
        else
        begin
            kind_sel = ira_pkg::PRE_NONE;
        end

        if (is_ptr || in_radix > ira_pkg::RADIX_MAX)
        begin
            radix_sel = ira_pkg::RADIX_MAX;
        end
        else if (in_radix < ira_pkg::RADIX_MIN)
        begin
            radix_sel = ira_pkg::RADIX_MIN;
        end
        else
        begin
            radix_sel = in_radix;
        end

        mag_sel = is_neg ? (~in_value + 1'b1) : in_value;
    end

    // Start the divider on the item itself unless it prints "(nil)", then again on each nonzero quotient.
    assign div_start    = (in_xfer && kind_sel != ira_pkg::PRE_NIL)
                       || (state_reg == S_DIV && div_done && div_quot != '0);
    assign div_dividend = in_xfer ? mag_sel : div_quot;
    assign div_divisor  = in_xfer ? radix_sel : radix_reg;

    ira_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Character selection: prefix first, then the stored digits in reverse.
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit      = (state_reg == S_EMIT) && out_free;
    assign pre_len   = ira_pkg::prefix_len(pre_kind_reg);
    assign in_prefix = (pre_idx_reg < pre_len);
    assign rd_idx    = ira_pkg::DIG_IDX_W'(ndig_reg - 1'b1);

    always_comb
    begin
        if (in_prefix)
        begin
            emit_ch   = ira_pkg::prefix_char(pre_kind_reg, pre_idx_reg);
            emit_last = (pre_idx_reg == pre_len - 3'd1) && (ndig_reg == '0);
        end
        else
        begin
            emit_ch   = ira_pkg::digit_char(dig_reg[rd_idx], upper_reg);
            emit_last = (ndig_reg == ira_pkg::DIG_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pre_kind_reg  <= ira_pkg::PRE_NONE;
            pre_idx_reg   <= '0;
            ndig_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        pre_kind_reg <= kind_sel;
                        pre_idx_reg  <= '0;
                        ndig_reg     <= '0;
                        state_reg    <= (kind_sel == ira_pkg::PRE_NIL) ? S_EMIT : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        ndig_reg <= ndig_reg + 1'b1;
                        if (div_quot == '0)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (emit)
                    begin
                        if (in_prefix)
                        begin
                            pre_idx_reg <= pre_idx_reg + 3'd1;
                        end
                        else
                        begin
                            ndig_reg <= ndig_reg - 1'b1;
                        end
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            radix_reg <= radix_sel;
            upper_reg <= in_upper && !is_ptr;
        end
        if (state_reg == S_DIV && div_done)
        begin
            dig_reg[ira_pkg::DIG_IDX_W'(ndig_reg)] <= div_rem;
        end
        if (emit)
        begin
            out_ch_reg   <= emit_ch;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_ch_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= ira_pkg::DIG_CNT_W'(ira_pkg::MAX_DIGITS))
        else $error("digit buffer overflow");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    a_emit_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (in_prefix || ndig_reg != '0))
        else $error("emit state with nothing to send");
`endif

endmodule

@@ tb/sv/ascii_stream_checker.sv @@
// Checker for the integer to ASCII formatter: predicts each character and compares transfers.
module ascii_stream_checker
    import ira_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd[1:0], value[65:2], radix[70:66], upper_case[71]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,  // ch[7:0]
    input  logic        m_axis_tlast,  // last
    output int          error_count,
    output int          pending_count,
    output int          checked_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_char_t;

    ascii_char_t expected_chars [$];
    int          mismatches;
    int          chars_seen;

    // Build the formatted text of one number and queue its characters.
    function automatic void predict_chars(input logic [1:0] cmd, input logic [63:0] value,
                                          input logic [4:0] radix_in, input logic upper);
        logic [7:0]  text [$];
        logic [7:0]  rev [$];
        logic [63:0] mag;
        logic [63:0] base;
        logic [7:0]  digit;
        logic        use_upper;
        logic        has_digits;
        base = {59'd0, radix_in};
        if (radix_in < RADIX_MIN)
        begin
            base = {59'd0, RADIX_MIN};
        end
        else if (radix_in > RADIX_MAX)
        begin
            base = {59'd0, RADIX_MAX};
        end
        use_upper = upper;
        has_digits = 1'b1;
        mag = value;
        if (cmd == CMD_POINTER)
        begin
            // pointers ignore radix and case: always lowercase hex
            base = {59'd0, RADIX_MAX};
            use_upper = 1'b0;
            if (value == 64'd0)
            begin
                text = {CH_LPAREN, CH_N, CH_I, CH_L, CH_RPAREN};
                has_digits = 1'b0;
            end
            else
            begin
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
            end
        end
        else if (cmd == CMD_SIGNED && value[63])
        begin
            // magnitude of the most negative value still fits in 64 unsigned bits
            text.push_back(CH_MINUS);
            mag = 64'd0 - value;
        end
        if (has_digits)
        begin
            do
            begin
                digit = 8'(mag % base);
                if (digit < 8'd10)
                begin
                    rev.push_front(CH_ZERO + digit);
                end
                else
                begin
                    rev.push_front((use_upper ? CH_UPPER : CH_LOWER) + digit - 8'd10);
                end
                mag = mag / base;
            end
            while (mag != 64'd0);
            foreach (rev[i])
            begin
                text.push_back(rev[i]);
            end
        end
        foreach (text[i])
        begin
            expected_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ascii_char_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            mismatches = 0;
            chars_seen = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_chars(s_axis_tdata[1:0], s_axis_tdata[65:2], s_axis_tdata[70:66],
                              s_axis_tdata[71]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected transfer: expected none, actual ch=%h last=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.ch)
                    begin
                        $display("%0t: ch mismatch: expected %h, actual %h",
                                 $time, want.ch, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_chars.size();
        checked_count <= chars_seen;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the testbench: clock, reset, number stimulus, output back-pressure and verdict.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ira_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 460;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int DRAIN_CYCLES    = 250;
    localparam int CYCLE_LIMIT     = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        hold_off_req = 1'b0;

    int error_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int burst_left = 0;
    int items_by_cmd [4] = '{0, 0, 0, 0};

    integer_radix_to_ascii u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ascii_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** integer_radix_to_ascii: FAILED **");
            $finish;
        end
    end

    // Offer one number; called at a rising edge, returns at the edge of its transfer.
    task automatic send_number(input logic [1:0] cmd, input logic [63:0] value,
                               input logic [4:0] radix, input logic upper);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 250) : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {upper, radix, value, cmd};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        burst_left--;
        items_by_cmd[cmd]++;
    endtask

    // Output back-pressure: patterns of random length, plus one long hold-off.
    initial
    begin : receiver
        int  span;
        int  pattern;
        logic held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            pattern = $urandom_range(0, 3);
            span = $urandom_range(16, 256);
            repeat (span)
            begin
                @(posedge clk);
                case (pattern)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [1:0]  cmd;
        logic [63:0] value;
        logic [4:0]  radix;
        int          pick;
        int          shift;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, sign extremes and the most negative value
        send_number(CMD_SIGNED,   64'd0,                  RADIX_MIN, 1'b0);
        send_number(CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, RADIX_MIN, 1'b0);
        send_number(CMD_SIGNED,   64'h8000_0000_0000_0000, RADIX_MIN, 1'b0);
        send_number(CMD_SIGNED,   64'h8000_0000_0000_0000, RADIX_MAX, 1'b1);
        send_number(CMD_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, RADIX_MIN, 1'b0);
        send_number(CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FF01, RADIX_MAX, 1'b1);
        send_number(CMD_UNSIGNED, 64'd0,                  RADIX_MAX, 1'b1);
        send_number(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, RADIX_MIN, 1'b0);
        send_number(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, RADIX_MAX, 1'b1);
        send_number(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, RADIX_MAX, 1'b0);
        send_number(CMD_UNSIGNED, 64'd9,                  RADIX_MIN, 1'b0);
        send_number(CMD_UNSIGNED, 64'd10,                 RADIX_MIN, 1'b0);
        send_number(CMD_UNSIGNED, 64'h0000_0000_00AB_CDEF, RADIX_MAX, 1'b0);
        send_number(CMD_UNSIGNED, 64'h0123_4567_89AB_CDEF, 5'd13,    1'b1);
        // radix saturation below and above the legal range
        send_number(CMD_UNSIGNED, 64'd12345,              5'd0,     1'b0);
        send_number(CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FF85, 5'd9,     1'b1);
        send_number(CMD_UNSIGNED, 64'h0000_0000_DEAD_BEEF, 5'd17,    1'b1);
        send_number(CMD_UNSIGNED, 64'h0000_0000_DEAD_BEEF, 5'd31,    1'b0);
        // pointers: nil, radix and case ignored
        send_number(CMD_POINTER,  64'd0,                  RADIX_MIN, 1'b0);
        send_number(CMD_POINTER,  64'd0,                  5'd31,    1'b1);
        send_number(CMD_POINTER,  64'h0000_0000_DEAD_BEEF, RADIX_MIN, 1'b1);
        send_number(CMD_POINTER,  64'hFFFF_FFFF_FFFF_FFFF, RADIX_MAX, 1'b1);
        send_number(CMD_POINTER,  64'd1,                  5'd0,     1'b0);
        // unused mode formats as unsigned
        send_number(CMD_UNUSED,   64'hFFFF_FFFF_FFFF_FFFE, RADIX_MIN, 1'b0);
        send_number(CMD_UNUSED,   64'd0,                  RADIX_MAX, 1'b1);

        hold_off_req <= 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 9);
            cmd = (pick < 4) ? CMD_SIGNED : (pick < 7) ? CMD_UNSIGNED :
                  (pick < 9) ? CMD_POINTER : CMD_UNUSED;
            pick = $urandom_range(0, 9);
            radix = (pick < 4) ? RADIX_MIN : (pick < 7) ? RADIX_MAX :
                    (pick < 9) ? 5'($urandom_range(11, 15)) : 5'($urandom_range(0, 31));
            case ($urandom_range(0, 5))
                0: value = {$urandom, $urandom};
                1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: value = 64'd0 - ({32'd0, $urandom} >> $urandom_range(0, 31));
                3:
                begin
                    shift = $urandom_range(0, 63);
                    value = 64'd1 << shift;
                    if ($urandom_range(0, 1) != 0)
                    begin
                        value = value - 64'd1;
                    end
                end
                4: value = ($urandom_range(0, 1) != 0)
                           ? 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 2))
                           : 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2));
                default: value = 64'($urandom_range(0, 20));
            endcase
            send_number(cmd, value, radix, 1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        // let the checker queue the final transfer before watching its count
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d signed, %0d unsigned, %0d pointer and %0d unused-mode numbers,",
                 items_by_cmd[CMD_SIGNED], items_by_cmd[CMD_UNSIGNED],
                 items_by_cmd[CMD_POINTER], items_by_cmd[CMD_UNUSED]);
        $display("with radix saturation and a long output hold-off; %0d characters compared.",
                 checked_count);
        if (error_count == 0 && pending_count == 0)
        begin
            $display("** integer_radix_to_ascii: PASSED **");
        end
        else
        begin
            $display("** integer_radix_to_ascii: FAILED **");
        end
        $finish;
    end

endmodule
